### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions in the RTL folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// An antecedent that, once seen, requires a consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/tspat_pkg.sv
// ----------------------------------------------------------------------------
// tspat_pkg
// Types and constants shared by the transport stream PAT parser.
// ----------------------------------------------------------------------------
package tspat_pkg;

  localparam int unsigned PACKET_BYTES = 188;

  localparam logic [7:0]  TS_SYNC_MARK    = 8'h47;
  localparam logic [11:0] MIN_SECTION_LEN = 12'd13;
  localparam logic [11:0] MIN_CRC_LEN     = 12'd6;

  // Byte offsets from the packet start, less the pointer field value.
  localparam logic [7:0] OFS_TABLE_ID   = 8'd5;
  localparam logic [7:0] OFS_LENGTH_LO  = 8'd7;
  localparam logic [7:0] OFS_TSID_HI    = 8'd8;
  localparam logic [7:0] OFS_SECT_END   = 8'd12;
  localparam logic [7:0] OFS_FIRST_PROG = 8'd16;

  typedef enum logic [1:0] {
    REC_HEADER  = 2'd0,
    REC_SECTION = 2'd1,
    REC_ENTRY   = 2'd2,
    REC_CRC     = 2'd3
  } rec_kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_start;
  } in_item_t;

  typedef struct packed {
    rec_kind_e   record_kind;
    logic [12:0] packet_pid;
    logic [15:0] number_word;
    logic [7:0]  table_kind;
    logic [11:0] section_size;
    logic [4:0]  version;
    logic        current_next;
    logic [7:0]  section_index;
    logic [7:0]  last_section_index;
    logic [31:0] crc_value;
    logic [7:0]  header_flags;
    logic [2:0]  status_flags;
  } pat_rec_t;

endpackage

### hw/rtl/ts_pat_section_parser.sv
// ----------------------------------------------------------------------------
// ts_pat_section_parser
// Transport stream packet header and PAT section parser, one byte per cycle while records are taken.
// ----------------------------------------------------------------------------
// Stream bytes enter on the slave channel, one byte per request, with tuser
// marking the first byte of a packet; without that mark the byte position
// simply wraps after the last byte of a packet. Records leave on the master
// channel: tuser carries the record kind (packet header, section header,
// program entry or section CRC) and tdata the packed record fields.
// Each accepted byte is captured in an input register, decoded in one pass
// of short logic against the parser state, and any record it produces is
// written to the output register. A record is offered from there once its
// last byte has left the input register. Throughput is one byte per cycle
// while the receiver takes records; the only limit is the single output
// register, which must be free before the input register may move on.
// A stalled receiver holds up the stream once a further byte reaches the
// decode stage, whether or not that byte produces a record.
// Reset clears the byte position, the continuity tracking and all held
// header and section fields, and empties both registers. While the receiver
// stalls, the pending record stays unchanged in the output register and
// tready falls as soon as the input register also holds a byte.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ts_pat_section_parser
  import tspat_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]   s_axis_tuser,   // [0] packet_start
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [12:0] packet_pid, [28:13] number_word, [36:29] table_kind,
  // [48:37] section_size, [53:49] version, [54] current_next,
  // [62:55] section_index, [70:63] last_section_index, [102:71] crc_value,
  // [110:103] header_flags, [113:111] status_flags, [119:114] zero
  output logic [119:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser    // [1:0] record_kind
);

  // Input stage: one byte waiting for decode.
  logic     in_valid_q, in_valid_d;
  in_item_t in_item_q;

  // Output stage: one finished record waiting for the receiver.
  logic     out_valid_q, out_valid_d;
  pat_rec_t out_rec_q;

  logic     s_accept;
  logic     out_free;
  logic     advance;
  logic     core_valid;
  pat_rec_t core_rec;

  // The decode stage may move on only when its possible record has a home.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  tspat_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (in_item_q),
    .rec_valid_o (core_valid),
    .rec_o       (core_rec)
  );

  always_comb begin
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end

    if (advance && core_valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_item_q.data_byte    <= s_axis_tdata;
      in_item_q.packet_start <= s_axis_tuser[0];
    end
    if (advance && core_valid) begin
      out_rec_q <= core_rec;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_rec_q.record_kind;
  assign m_axis_tdata  = {6'b0,
                          out_rec_q.status_flags,
                          out_rec_q.header_flags,
                          out_rec_q.crc_value,
                          out_rec_q.last_section_index,
                          out_rec_q.section_index,
                          out_rec_q.current_next,
                          out_rec_q.version,
                          out_rec_q.section_size,
                          out_rec_q.table_kind,
                          out_rec_q.number_word,
                          out_rec_q.packet_pid};

  // An accepted byte always lands in the decode stage.
  `ASSERT_NEXT(a_accept_fills_stage, clk_i, rst_ni, s_accept, in_valid_q,
               "accepted byte did not reach the decode stage")

  // A decoded record is always offered on the next cycle.
  `ASSERT_NEXT(a_record_offered, clk_i, rst_ni, advance && core_valid, m_axis_tvalid,
               "decoded record was not presented")

  // Only packet header records carry header and continuity flags.
  `ASSERT_ALWAYS(a_header_fields_only, clk_i, rst_ni,
                 !m_axis_tvalid || (m_axis_tuser == REC_HEADER)
                 || ((m_axis_tdata[110:103] == 8'd0) && (m_axis_tdata[111] == 1'b0)),
                 "non-header record carries header flags")

endmodule

### hw/rtl/tspat_core.sv
// ----------------------------------------------------------------------------
// tspat_core
// Per-byte parser state and record decode for one stream byte per step.
// ----------------------------------------------------------------------------
module tspat_core
  import tspat_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  in_item_t item_i,
  output logic     rec_valid_o,
  output pat_rec_t rec_o
);

  logic [7:0]  byte_pos_q, byte_pos_d;
  logic [12:0] held_pid_q, held_pid_d;
  logic [7:0]  held_flags_q, held_flags_d;
  logic [3:0]  exp_cc_q, exp_cc_d;
  logic        first_seen_q, first_seen_d;
  logic        table_act_q, table_act_d;
  logic [7:0]  pointer_q, pointer_d;
  logic [11:0] held_len_q, held_len_d;
  logic [31:0] recent_q, recent_d;
  logic [15:0] sect_q, sect_d;

  logic [7:0]  b;
  logic [7:0]  pos;
  logic [8:0]  pos_inc;
  logic [7:0]  r;
  logic [3:0]  cc;
  logic [3:0]  exp_new;
  logic [7:0]  vb;
  logic        in_section;
  logic        is_entry;
  logic        is_crc;
  logic [2:0]  sect_st;

  always_comb begin
    b = item_i.data_byte;
    if (item_i.packet_start || ({1'b0, byte_pos_q} >= 9'(PACKET_BYTES))) begin
      pos = 8'd0;
    end else begin
      pos = byte_pos_q;
    end
    pos_inc = {1'b0, pos} + 9'd1;
    recent_d = {recent_q[23:0], b};
    r = pos - pointer_q;
    cc = b[3:0];
    vb = recent_d[23:16];
    in_section = ({1'b0, pos} >= ({1'b0, pointer_q} + {1'b0, OFS_TABLE_ID}));
    is_entry = (r >= OFS_FIRST_PROG) && (r[1:0] == 2'b00)
               && (({4'b0, r} - 12'd3) <= held_len_q);
    is_crc = (held_len_q >= MIN_CRC_LEN)
             && ({5'b0, r} == ({1'b0, held_len_q} + 13'd7));
    sect_st = 3'b000;
    if (held_len_q < MIN_SECTION_LEN) begin
      sect_st[1] = 1'b1;
    end
    if (({5'b0, pointer_q} + {1'b0, held_len_q} + 13'd8) > 13'(PACKET_BYTES)) begin
      sect_st[2] = 1'b1;
    end
    exp_new = first_seen_q ? (exp_cc_q + 4'd1) : cc;

    if (pos_inc >= 9'(PACKET_BYTES)) begin
      byte_pos_d = 8'd0;
    end else begin
      byte_pos_d = pos_inc[7:0];
    end
    held_pid_d   = held_pid_q;
    held_flags_d = held_flags_q;
    exp_cc_d     = exp_cc_q;
    first_seen_d = first_seen_q;
    table_act_d  = table_act_q;
    pointer_d    = pointer_q;
    held_len_d   = held_len_q;
    sect_d       = sect_q;

    rec_valid_o = 1'b0;
    rec_o       = '0;

    priority if (pos == 8'd0) begin
      table_act_d  = 1'b0;
      held_pid_d   = '0;
      held_flags_d = {7'b0, (b != TS_SYNC_MARK)};
    end else if (pos == 8'd1) begin
      held_flags_d = held_flags_q | {4'b0, b[5], b[6], b[7], 1'b0};
      held_pid_d   = {b[4:0], 8'b0};
    end else if (pos == 8'd2) begin
      held_pid_d = held_pid_q | {5'b0, b};
    end else if (pos == 8'd3) begin
      held_flags_d = {b[5:4], b[7:6], held_flags_q[3:0]};
      rec_valid_o  = 1'b1;
      rec_o.record_kind  = REC_HEADER;
      rec_o.packet_pid   = held_pid_q;
      rec_o.header_flags = held_flags_d;
      if (held_pid_q == '0) begin
        exp_cc_d     = exp_new;
        first_seen_d = 1'b1;
        rec_o.status_flags = {2'b00, (exp_new != cc)};
      end
      table_act_d = (held_pid_q == '0) && (b[5:4] == 2'b01);
    end else if (table_act_q) begin
      if (pos == 8'd4) begin
        pointer_d = b;
      end else if (in_section) begin
        priority if (r == OFS_TABLE_ID) begin
          sect_d[7:0] = b;
        end else if (r == OFS_LENGTH_LO) begin
          held_len_d = {recent_d[11:8], b};
        end else if (r == OFS_TSID_HI) begin
          sect_d[15:8] = b;
        end else if (r == OFS_SECT_END) begin
          rec_valid_o = 1'b1;
          rec_o.record_kind        = REC_SECTION;
          rec_o.number_word        = {sect_q[15:8], recent_d[31:24]};
          rec_o.table_kind         = sect_q[7:0];
          rec_o.section_size       = held_len_q;
          rec_o.version            = vb[5:1];
          rec_o.current_next       = vb[0];
          rec_o.section_index      = recent_d[15:8];
          rec_o.last_section_index = recent_d[7:0];
          rec_o.status_flags       = sect_st;
        end else if (is_entry) begin
          rec_valid_o = 1'b1;
          rec_o.record_kind = REC_ENTRY;
          rec_o.packet_pid  = recent_d[12:0];
          rec_o.number_word = recent_d[31:16];
        end else if (is_crc) begin
          rec_valid_o = 1'b1;
          rec_o.record_kind = REC_CRC;
          rec_o.crc_value   = recent_d;
        end else begin
          rec_valid_o = 1'b0;
        end
      end
    end else begin
      rec_valid_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q   <= '0;
      held_pid_q   <= '0;
      held_flags_q <= '0;
      exp_cc_q     <= '0;
      first_seen_q <= 1'b0;
      table_act_q  <= 1'b0;
      pointer_q    <= '0;
      held_len_q   <= '0;
      recent_q     <= '0;
      sect_q       <= '0;
    end else if (step_i) begin
      byte_pos_q   <= byte_pos_d;
      held_pid_q   <= held_pid_d;
      held_flags_q <= held_flags_d;
      exp_cc_q     <= exp_cc_d;
      first_seen_q <= first_seen_d;
      table_act_q  <= table_act_d;
      pointer_q    <= pointer_d;
      held_len_q   <= held_len_d;
      recent_q     <= recent_d;
      sect_q       <= sect_d;
    end
  end

endmodule
